// ===== rtl/core/cles_pkg.sv =====
// Shared types, constants and init-sequence decoding for the LCD expander sequencer.
package cles_pkg;

	// Operation codes of the input channel
	typedef enum logic [2:0] {
		OP_INIT      = 3'd0,
		OP_CMD       = 3'd1,
		OP_DATA      = 3'd2,
		OP_CURSOR    = 3'd3,
		OP_CLEAR     = 3'd4,
		OP_HOME      = 3'd5,
		OP_BACKLIGHT = 3'd6,
		OP_NONE      = 3'd7
	} op_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_BUS_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_COLUMNS     = 2'd1;
	localparam logic [1:0] CFG_ROWS        = 2'd2;

	// Configuration reset values
	localparam logic [6:0] BUS_ADDRESS_RST = 7'd39;
	localparam logic [5:0] COLUMNS_RST     = 6'd20;
	localparam logic [2:0] ROWS_RST        = 3'd4;

	// Display size limits for cursor clamping
	localparam logic [2:0] ROW_COUNT_MAX    = 3'd4;
	localparam logic [5:0] COLUMN_COUNT_MAX = 6'd40;

	// LCD command bytes
	localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
	localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] LCD_DISPLAY_OFF  = 8'h08;
	localparam logic [7:0] LCD_CLEAR        = 8'h01;
	localparam logic [7:0] LCD_HOME         = 8'h02;
	localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
	localparam logic [3:0] NIB_WAKE         = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	// Wait times in microseconds
	localparam logic [15:0] WAIT_POWER_UP   = 16'd50000;
	localparam logic [12:0] WAIT_STROBE     = 13'd1;
	localparam logic [12:0] WAIT_NIBBLE     = 13'd50;
	localparam logic [12:0] WAIT_BL_INIT    = 13'd1000;
	localparam logic [12:0] WAIT_WAKE_LONG  = 13'd4550;
	localparam logic [12:0] WAIT_WAKE_SHORT = 13'd250;
	localparam logic [12:0] WAIT_CMD        = 13'd1650;
	localparam logic [12:0] WAIT_CMD_SLOW   = 13'd3650;
	localparam logic [12:0] WAIT_DATA       = 13'd100;

	// Write counts per operation
	localparam logic [4:0] INIT_WRITES = 5'd29;
	localparam logic [4:0] BYTE_WRITES = 5'd4;
	localparam logic [4:0] BL_WRITES   = 5'd1;

	// Row start addresses in display memory
	localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic [4:0] step;
	} cmd_t;

	// One write of the init sequence, backlight added by the caller
	typedef struct packed {
		logic [3:0]  nib;
		logic        e;
		logic [12:0] after;
	} init_wr_t;

	function automatic logic [4:0] write_count(input op_t op);
		logic [4:0] n;
		case (op)
			OP_INIT:      n = INIT_WRITES;
			OP_BACKLIGHT: n = BL_WRITES;
			OP_NONE:      n = 5'd0;
			default:      n = BYTE_WRITES;
		endcase
		return n;
	endfunction

	function automatic init_wr_t init_write(input logic [4:0] step);
		logic [4:0] s;
		logic [4:0] t;
		logic [7:0] cb;
		init_wr_t   r;
		s = step - 5'd1;
		t = step - 5'd9;
		cb = LCD_DISPLAY_ON;
		r = '0;
		if (step == 5'd0) begin
			r.after = WAIT_BL_INIT;
		end else if (step < 5'd9) begin
			// wake-up nibbles: three 0x3 then one 0x2
			r.nib = (s[2:1] == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
			r.e = ~s[0];
			r.after = s[0] ? (s[2] ? WAIT_WAKE_SHORT : WAIT_WAKE_LONG) : WAIT_STROBE;
		end else begin
			case (t[4:2])
				3'd0:    cb = LCD_FUNCTION_SET;
				3'd1:    cb = LCD_DISPLAY_OFF;
				3'd2:    cb = LCD_CLEAR;
				3'd3:    cb = LCD_ENTRY_MODE;
				default: cb = LCD_DISPLAY_ON;
			endcase
			r.nib = t[1] ? cb[3:0] : cb[7:4];
			r.e = ~t[0];
			if (t[1:0] == 2'd3) begin
				r.after = (t[4:2] == 3'd2) ? WAIT_CMD_SLOW : WAIT_CMD;
			end else begin
				r.after = t[0] ? WAIT_NIBBLE : WAIT_STROBE;
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/cles_ctrl.sv =====
// Controller state machine: input/output handshakes and the write step counter.
module cles_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        operation,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              last,
	output cles_pkg::cmd_t    cmd
);
	import cles_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic [4:0] last_step_q;
	logic [4:0] count;
	logic       in_xfer;
	logic       out_xfer;

	assign count    = write_count(op_t'(operation));
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_valid = (state_q == S_RUN);
	assign out_xfer = out_valid && out_ready;
	assign last     = (step_q == last_step_q);

	assign cmd.load = in_xfer;
	assign cmd.step = step_q;

	// Advance through the writes of one operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			last_step_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && (count != 5'd0)) begin
						state_q     <= S_RUN;
						step_q      <= '0;
						last_step_q <= count - 5'd1;
					end
				end
				S_RUN: begin
					if (out_xfer) begin
						if (last) begin
							state_q <= S_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 5'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Final transfer of an operation frees the input side
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready)
		else $error("input not ready after final transfer");

	// Step counter never passes the final write
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (step_q <= last_step_q))
		else $error("step counter beyond final write");

	// Unused operation code produces no writes
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (operation == OP_NONE) |=> !out_valid)
		else $error("writes issued for unused operation");

endmodule

// ===== rtl/core/cles_dp.sv =====
// Datapath: configuration registers, operation latch and expander byte formatting.
module cles_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cles_pkg::cmd_t    cmd,
	input  logic [2:0]        operation,
	input  logic [7:0]        value,
	input  logic [1:0]        row,
	input  logic [5:0]        col,
	input  logic              backlight_on,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	output logic [6:0]        bus_address_res,
	output logic [7:0]        expander_byte,
	output logic [15:0]       wait_before_us,
	output logic [12:0]       wait_after_us
);
	import cles_pkg::*;

	logic [6:0] bus_address_q;
	logic [5:0] columns_q;
	logic [2:0] rows_q;
	logic       bl_q;
	op_t        op_q;
	logic [7:0] byte_q;
	logic       rs_q;

	op_t        op_in;
	logic [2:0] eff_rows;
	logic [5:0] eff_cols;
	logic [2:0] row_c;
	logic [5:0] col_c;
	logic [7:0] cursor_addr;
	logic [7:0] load_byte;
	init_wr_t   iw;
	logic [1:0] w;
	logic [3:0] nib;

	assign op_in = op_t'(operation);

	// Saturate the display size and clamp the cursor target
	always_comb begin
		eff_rows = rows_q;
		if (rows_q == 3'd0) eff_rows = 3'd1;
		else if (rows_q > ROW_COUNT_MAX) eff_rows = ROW_COUNT_MAX;
		eff_cols = columns_q;
		if (columns_q == 6'd0) eff_cols = 6'd1;
		else if (columns_q > COLUMN_COUNT_MAX) eff_cols = COLUMN_COUNT_MAX;
		row_c = {1'b0, row};
		if (row_c >= eff_rows) row_c = eff_rows - 3'd1;
		col_c = col;
		if (col_c >= eff_cols) col_c = eff_cols - 6'd1;
		cursor_addr = ROW_BASE[row_c[1:0]] + {2'b00, col_c};
	end

	// Pick the logical byte for the operation
	always_comb begin
		case (op_in)
			OP_CMD:    load_byte = value;
			OP_DATA:   load_byte = value;
			OP_CURSOR: load_byte = LCD_SET_DDRAM | cursor_addr;
			OP_CLEAR:  load_byte = LCD_CLEAR;
			OP_HOME:   load_byte = LCD_HOME;
			default:   load_byte = 8'h00;
		endcase
	end

	// Hold configuration and backlight state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_address_q <= BUS_ADDRESS_RST;
			columns_q     <= COLUMNS_RST;
			rows_q        <= ROWS_RST;
			bl_q          <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BUS_ADDRESS: bus_address_q <= cfg_data;
					CFG_COLUMNS:     columns_q <= cfg_data[5:0];
					CFG_ROWS:        rows_q <= cfg_data[2:0];
					default:         ;
				endcase
			end
			if (cmd.load) begin
				if (op_in == OP_INIT) bl_q <= 1'b1;
				else if (op_in == OP_BACKLIGHT) bl_q <= backlight_on;
			end
		end
	end

	// Latch the operation payload on input transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_in;
			byte_q <= load_byte;
			rs_q   <= (op_in == OP_DATA);
		end
	end

	assign iw  = init_write(cmd.step);
	assign w   = cmd.step[1:0];
	assign nib = w[1] ? byte_q[3:0] : byte_q[7:4];

	// Format the current expander write
	always_comb begin
		bus_address_res = bus_address_q;
		wait_before_us  = '0;
		case (op_q)
			OP_INIT: begin
				expander_byte = {iw.nib, bl_q, iw.e, 2'b00};
				wait_after_us = iw.after;
				if (cmd.step == 5'd0) wait_before_us = WAIT_POWER_UP;
			end
			OP_BACKLIGHT: begin
				expander_byte = {4'h0, bl_q, 3'b000};
				wait_after_us = '0;
			end
			default: begin
				expander_byte = {nib, bl_q, ~w[0], 1'b0, rs_q};
				if (!w[0]) wait_after_us = WAIT_STROBE;
				else if (!w[1]) wait_after_us = WAIT_NIBBLE;
				else if (op_q == OP_DATA) wait_after_us = WAIT_DATA;
				else if (op_q == OP_CLEAR || op_q == OP_HOME) wait_after_us = WAIT_CMD_SLOW;
				else wait_after_us = WAIT_CMD;
			end
		endcase
	end

endmodule

// ===== rtl/core/char_lcd_expander_sequencer_top.sv =====
// Top level of the character LCD sequencer for a 4-bit bus behind an I/O expander.
//
// Input channel (in_valid/in_ready) takes one LCD operation: init, command,
// data, set cursor, clear, home or backlight. Output channel
// (out_valid/out_ready) delivers one expander write per transfer with its bus
// address, expander byte and the waits before and after it; last marks the
// final write of an operation. Configuration (cfg_valid/cfg_ready) writes bus
// address, columns or rows by index and is always ready.
// Latency: the first write is valid the cycle after the input transfer.
// Throughput: one write per cycle while out_ready is high; an operation issues
// N writes (init 29, byte operations 4, backlight 1), counted by the
// controller's step counter, which serves one operation at a time. The
// unused operation code is accepted and produces nothing.
// Reset: no write pending, bus address 39, 20 columns, 4 rows, backlight on.
// When the receiver stalls, the current write holds and no new operation is
// accepted until the final write of the current one transfers.
module char_lcd_expander_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  value,
	input  logic [1:0]  row,
	input  logic [5:0]  col,
	input  logic        backlight_on,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  bus_address_res,
	output logic [7:0]  expander_byte,
	output logic [15:0] wait_before_us,
	output logic [12:0] wait_after_us,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import cles_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	cles_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last      (last),
		.cmd       (cmd)
	);

	cles_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.value           (value),
		.row             (row),
		.col             (col),
		.backlight_on    (backlight_on),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.bus_address_res (bus_address_res),
		.expander_byte   (expander_byte),
		.wait_before_us  (wait_before_us),
		.wait_after_us   (wait_after_us)
	);

endmodule
